>>> hdl/net_launcher_payload_controller_top_macros.svh
// Assertion helpers shared by the payload controller.
`ifndef NET_LAUNCHER_PAYLOAD_CONTROLLER_TOP_MACROS_SVH
`define NET_LAUNCHER_PAYLOAD_CONTROLLER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NLPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NLPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/nlpc_pkg.sv
package nlpc_pkg;

   // Field widths.
   localparam int OP_W      = 3;
   localparam int SEL_W     = 2;
   localparam int TRIM_W    = 11;
   localparam int TARGET_W  = 10;
   localparam int PITCH_W   = 16;
   localparam int ELAPSED_W = 16;
   localparam int PCMD_W    = 14;
   localparam int PWM_W     = 12;
   localparam int CUT_W     = 10;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int ANGLE_W   = 16;
   localparam int RANGE_W   = 15;
   localparam int TIMER_W   = 16;

   // The scaled product never exceeds 18000 * 1000, which fits in 25 bits.
   localparam int PROD_W = 25;
   localparam int STEP_W = $clog2(PROD_W);

   localparam int MAX_BARRELS = 2;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_TICK = 3'd0;
   localparam logic [OP_W-1:0] OP_FIRE = 3'd1;
   localparam logic [OP_W-1:0] OP_TRIM = 3'd2;
   localparam logic [OP_W-1:0] OP_CUT  = 3'd3;
   localparam logic [OP_W-1:0] OP_AIM  = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ANGLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ANGLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEW      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD      = 2'd3;

   localparam logic [SEL_W-1:0] SEL_ALL = 2'd0;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_NORMAL = 2'd0;
   localparam mode_type MODE_FIRED  = 2'd1;
   localparam mode_type MODE_CUT    = 2'd2;

   typedef logic [1:0] bcmd_kind_type;
   localparam bcmd_kind_type BCMD_NONE = 2'd0;
   localparam bcmd_kind_type BCMD_TICK = 2'd1;
   localparam bcmd_kind_type BCMD_FIRE = 2'd2;
   localparam bcmd_kind_type BCMD_CUT  = 2'd3;

   localparam logic [PWM_W-1:0] PWM_LOW  = 12'd1000;
   localparam logic [PWM_W-1:0] PWM_HIGH = 12'd2100;
   localparam logic [CUT_W-1:0] CUT_ON   = 10'd1000;
   localparam logic [CUT_W-1:0] CUT_OFF  = 10'd0;

   typedef logic signed [ANGLE_W-1:0] angle_type;

   localparam angle_type MAX_ANGLE_LO = -16'sd1500;
   localparam angle_type MAX_ANGLE_HI = 16'sd13500;
   localparam angle_type MIN_ANGLE_LO = -16'sd4500;
   localparam angle_type MIN_GAP      = 16'sd3000;
   localparam logic [CSR_W-1:0] SLEW_LO = 16'd500;
   localparam logic [CSR_W-1:0] SLEW_HI = 16'd9000;
   localparam logic [RANGE_W-1:0] SCALE = 15'd1000;
   localparam logic signed [TRIM_W-1:0] TRIM_LIMIT = 11'sd1000;
   localparam logic [TARGET_W-1:0] TARGET_LIMIT = 10'd1000;

   localparam logic [CSR_W-1:0] RST_MAX_ANGLE = 16'd4500;
   localparam logic [CSR_W-1:0] RST_MIN_ANGLE = 16'hEE6C;
   localparam logic [CSR_W-1:0] RST_SLEW      = 16'd500;
   localparam logic [CSR_W-1:0] RST_HOLD      = 16'd1000;

   typedef struct packed {
      bcmd_kind_type          kind;
      logic [SEL_W-1:0]       sel;
      logic [ELAPSED_W-1:0]   elapsed;
      logic [TIMER_W-1:0]     hold;
   } barrel_cmd_type;

   typedef struct packed {
      logic                   start;
      angle_type              a;
      logic [RANGE_W-1:0]     b;
      logic [RANGE_W-1:0]     d;
   } md_req_type;

   typedef struct packed {
      logic                   busy;
      logic                   done;
      angle_type              quot;
   } md_rsp_type;

endpackage

>>> hdl/nlpc_req_if.sv
interface nlpc_req_if import nlpc_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [OP_W-1:0]             op;
   logic [SEL_W-1:0]            barrel_select;
   logic signed [TRIM_W-1:0]    trim_value;
   logic [TARGET_W-1:0]         target_value;
   logic signed [PITCH_W-1:0]   pitch_cd;
   logic [ELAPSED_W-1:0]        elapsed_ms;

   modport source (
      output valid, op, barrel_select, trim_value, target_value, pitch_cd, elapsed_ms,
      input  ready
   );
   modport sink (
      input  valid, op, barrel_select, trim_value, target_value, pitch_cd, elapsed_ms,
      output ready
   );
endinterface

>>> hdl/nlpc_rsp_if.sv
interface nlpc_rsp_if import nlpc_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [PCMD_W-1:0]    pitch_command;
   logic [PWM_W-1:0]            fire_pwm_first;
   logic [CUT_W-1:0]            cut_level_first;
   logic [PWM_W-1:0]            fire_pwm_second;
   logic [CUT_W-1:0]            cut_level_second;

   modport source (
      output valid, pitch_command, fire_pwm_first, cut_level_first,
             fire_pwm_second, cut_level_second,
      input  ready
   );
   modport sink (
      input  valid, pitch_command, fire_pwm_first, cut_level_first,
             fire_pwm_second, cut_level_second,
      output ready
   );
endinterface

>>> hdl/net_launcher_payload_controller_top.sv
// Fire, cut and unknown words go straight to the result stage; an update tick slews, sums and
// runs one scaling, a set-trim word one scaling and a set-target word two; the result can stall.
// One word at a time; each scaling runs in the shared multiply-divide unit (one multiply,
// then 25 quotient bits at one bit per cycle).
// Reset (synchronous, active high) restores the register defaults, puts both barrels
// in normal mode and clears the timers, the angles and the last pitch command.
`include "net_launcher_payload_controller_top_macros.svh"

module net_launcher_payload_controller_top import nlpc_pkg::*; #(
   parameter int NUM_BARRELS = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   nlpc_req_if.sink             req,
   nlpc_rsp_if.source           rsp,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   // Sequencer states. Each scaling goes through a launch state that starts the
   // shared unit and a wait state that collects its quotient.
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SLEW      = 4'd1;
   localparam logic [3:0] S_SUM       = 4'd2;
   localparam logic [3:0] S_PC_GO     = 4'd3;
   localparam logic [3:0] S_PC_WAIT   = 4'd4;
   localparam logic [3:0] S_TARG_GO   = 4'd5;
   localparam logic [3:0] S_TARG_WAIT = 4'd6;
   localparam logic [3:0] S_TRIM_GO   = 4'd7;
   localparam logic [3:0] S_TRIM_WAIT = 4'd8;
   localparam logic [3:0] S_FINISH    = 4'd9;

   logic [3:0] state_ff, state_in;

   // Configuration registers.
   logic [CSR_W-1:0] max_setting_ff, min_setting_ff, slew_setting_ff, hold_ff;

   // Limits derived from the configuration, captured when a word is accepted.
   angle_type           max_s, min_s, hi_c, lo_cap, lo_c, span_c;
   logic [CSR_W-1:0]    slew_c;
   angle_type           lo_ff, hi_ff;
   logic [RANGE_W-1:0]  range_ff;
   logic [CSR_W-1:0]    slew_ff;

   // Fields of the accepted word, clamped where the commands call for it.
   logic signed [TRIM_W-1:0]  trim_req_c, trim_req_ff;
   logic [TARGET_W-1:0]       targ_req_c, targ_req_ff;
   logic signed [PITCH_W-1:0] pitch_ff;

   // Mount state.
   angle_type                 mount_ff, mount_in;
   angle_type                 target_ff, target_in;
   angle_type                 trim_ff, trim_in;
   angle_type                 sum_ff, sum_in;
   logic signed [PCMD_W-1:0]  last_pc_ff, last_pc_in;

   // Slew and summing datapath.
   logic signed [ANGLE_W:0]   diff, slew_pos, slew_neg, step;
   logic signed [ANGLE_W+1:0] sum_wide, lo_wide, hi_wide;

   // Result word register.
   logic                      rsp_valid_ff;
   logic                      load_rsp;
   logic signed [PCMD_W-1:0]  pcmd_ff;
   logic [PWM_W-1:0]          fire_first_ff, fire_second_ff;
   logic [CUT_W-1:0]          cut_first_ff, cut_second_ff;

   logic           accept;
   barrel_cmd_type bcmd;
   mode_type       modes [MAX_BARRELS];
   md_req_type     md_req;
   md_rsp_type     md_rsp;

   // Conditions watched by the assertions.
   logic           in_wait;
   logic           barrel_word;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);

   // Configuration writes land directly; they must only be made while idle, which the block does not enforce.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_setting_ff  <= RST_MAX_ANGLE;
         min_setting_ff  <= RST_MIN_ANGLE;
         slew_setting_ff <= RST_SLEW;
         hold_ff         <= RST_HOLD;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_ANGLE: max_setting_ff  <= csr_write_data;
            CSR_MIN_ANGLE: min_setting_ff  <= csr_write_data;
            CSR_SLEW:      slew_setting_ff <= csr_write_data;
            CSR_HOLD:      hold_ff         <= csr_write_data;
         endcase
      end
   end

   // The upper limit is clamped first; the lower limit must then sit at least
   // 3000 centidegrees below it, so the span is always 3000 to 18000.
   assign max_s  = max_setting_ff;
   assign min_s  = min_setting_ff;
   assign hi_c   = (max_s < MAX_ANGLE_LO) ? MAX_ANGLE_LO :
                   (max_s > MAX_ANGLE_HI) ? MAX_ANGLE_HI : max_s;
   assign lo_cap = hi_c - MIN_GAP;
   assign lo_c   = (min_s < MIN_ANGLE_LO) ? MIN_ANGLE_LO :
                   (min_s > lo_cap) ? lo_cap : min_s;
   assign span_c = hi_c - lo_c;
   assign slew_c = (slew_setting_ff < SLEW_LO) ? SLEW_LO :
                   (slew_setting_ff > SLEW_HI) ? SLEW_HI : slew_setting_ff;

   assign trim_req_c = (req.trim_value > TRIM_LIMIT) ? TRIM_LIMIT :
                       (req.trim_value < -TRIM_LIMIT) ? -TRIM_LIMIT : req.trim_value;
   assign targ_req_c = (req.target_value > TARGET_LIMIT) ? TARGET_LIMIT : req.target_value;

   always_ff @(posedge clock) begin
      if (accept) begin
         lo_ff       <= lo_c;
         hi_ff       <= hi_c;
         range_ff    <= span_c[RANGE_W-1:0];
         slew_ff     <= slew_c;
         trim_req_ff <= trim_req_c;
         targ_req_ff <= targ_req_c;
         pitch_ff    <= req.pitch_cd;
      end
   end

   // Barrel commands take effect at the acceptance edge; the modes are then
   // settled before the result word is formed.
   always_comb begin
      bcmd.kind    = BCMD_NONE;
      bcmd.sel     = req.barrel_select;
      bcmd.elapsed = req.elapsed_ms;
      bcmd.hold    = hold_ff;
      if (accept) begin
         case (req.op)
            OP_TICK: bcmd.kind = BCMD_TICK;
            OP_FIRE: bcmd.kind = BCMD_FIRE;
            OP_CUT:  bcmd.kind = BCMD_CUT;
            default: bcmd.kind = BCMD_NONE;
         endcase
      end
   end

   nlpc_barrels #(
      .NUM_BARRELS (NUM_BARRELS)
   ) u_barrels (
      .clock (clock),
      .reset (reset),
      .cmd   (bcmd),
      .modes (modes)
   );

   nlpc_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   // Slew step: move toward the target by at most the slew rate.
   assign diff     = {target_ff[ANGLE_W-1], target_ff} - {mount_ff[ANGLE_W-1], mount_ff};
   assign slew_pos = {3'b000, slew_ff[ANGLE_W-3:0]};
   assign slew_neg = -slew_pos;
   assign step     = (diff > slew_pos) ? slew_pos : (diff < slew_neg) ? slew_neg : diff;

   // Mount angle plus pitch minus trim, clamped to the limits.
   assign sum_wide = {{2{mount_ff[ANGLE_W-1]}}, mount_ff}
                   + {{2{pitch_ff[PITCH_W-1]}}, pitch_ff}
                   - {{2{trim_ff[ANGLE_W-1]}}, trim_ff};
   assign lo_wide  = {{2{lo_ff[ANGLE_W-1]}}, lo_ff};
   assign hi_wide  = {{2{hi_ff[ANGLE_W-1]}}, hi_ff};

   always_comb begin
      state_in   = state_ff;
      mount_in   = mount_ff;
      target_in  = target_ff;
      trim_in    = trim_ff;
      sum_in     = sum_ff;
      last_pc_in = last_pc_ff;
      load_rsp   = 1'b0;
      md_req     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req.op)
                  OP_TICK: state_in = S_SLEW;
                  OP_TRIM: state_in = S_TRIM_GO;
                  OP_AIM:  state_in = S_TARG_GO;
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_SLEW: begin
            mount_in = mount_ff + step[ANGLE_W-1:0];
            state_in = S_SUM;
         end
         S_SUM: begin
            if (sum_wide < lo_wide) begin
               sum_in = lo_ff;
            end else if (sum_wide > hi_wide) begin
               sum_in = hi_ff;
            end else begin
               sum_in = sum_wide[ANGLE_W-1:0];
            end
            state_in = S_PC_GO;
         end
         S_PC_GO: begin
            // Pitch command = sum * 1000 / span.
            md_req.start = 1'b1;
            md_req.a     = sum_ff;
            md_req.b     = SCALE;
            md_req.d     = range_ff;
            state_in     = S_PC_WAIT;
         end
         S_PC_WAIT: begin
            if (md_rsp.done) begin
               last_pc_in = md_rsp.quot[PCMD_W-1:0];
               state_in   = S_FINISH;
            end
         end
         S_TARG_GO: begin
            // Target angle = target * span / 1000.
            md_req.start = 1'b1;
            md_req.a     = {{(ANGLE_W-TARGET_W){1'b0}}, targ_req_ff};
            md_req.b     = range_ff;
            md_req.d     = SCALE;
            state_in     = S_TARG_WAIT;
         end
         S_TARG_WAIT: begin
            if (md_rsp.done) begin
               target_in = md_rsp.quot;
               state_in  = S_TRIM_GO;
            end
         end
         S_TRIM_GO: begin
            // Trim angle = trim * span / 1000.
            md_req.start = 1'b1;
            md_req.a     = {{(ANGLE_W-TRIM_W){trim_req_ff[TRIM_W-1]}}, trim_req_ff};
            md_req.b     = range_ff;
            md_req.d     = SCALE;
            state_in     = S_TRIM_WAIT;
         end
         S_TRIM_WAIT: begin
            if (md_rsp.done) begin
               trim_in  = md_rsp.quot;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // The result register is refilled once the previous word has left.
            if (!rsp_valid_ff || rsp.ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         mount_ff   <= '0;
         target_ff  <= '0;
         trim_ff    <= '0;
         last_pc_ff <= '0;
      end else begin
         state_ff   <= state_in;
         mount_ff   <= mount_in;
         target_ff  <= target_in;
         trim_ff    <= trim_in;
         last_pc_ff <= last_pc_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   // Output word register: it holds a finished word while the sequencer is
   // already free to accept the next input word.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         pcmd_ff        <= last_pc_ff;
         fire_first_ff  <= (modes[0] == MODE_FIRED) ? PWM_HIGH : PWM_LOW;
         cut_first_ff   <= (modes[0] == MODE_CUT) ? CUT_ON : CUT_OFF;
         fire_second_ff <= (modes[1] == MODE_FIRED) ? PWM_HIGH : PWM_LOW;
         cut_second_ff  <= (modes[1] == MODE_CUT) ? CUT_ON : CUT_OFF;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.pitch_command    = pcmd_ff;
   assign rsp.fire_pwm_first   = fire_first_ff;
   assign rsp.cut_level_first  = cut_first_ff;
   assign rsp.fire_pwm_second  = fire_second_ff;
   assign rsp.cut_level_second = cut_second_ff;

   assign in_wait     = (state_ff == S_PC_WAIT) || (state_ff == S_TARG_WAIT) ||
                        (state_ff == S_TRIM_WAIT);
   assign barrel_word = accept && (req.op == OP_FIRE || req.op == OP_CUT);

   // While the shared unit is dividing, no new word may enter.
   `NLPC_ASSERT_NOW(a_busy_blocks_input, clock, reset, md_rsp.busy, !req.ready, "busy input")

   // The unit only finishes while the sequencer is waiting for it.
   `NLPC_ASSERT_NOW(a_done_in_wait, clock, reset, md_rsp.done, in_wait, "done outside wait")

   // Fire and cut words need no arithmetic and go straight to the result stage.
   `NLPC_ASSERT_NEXT(a_barrel_short, clock, reset, barrel_word, state_ff == S_FINISH, "late")

   // A new result word only appears after a load out of the finishing state.
   `NLPC_ASSERT_NOW(a_rsp_from_finish, clock, reset, $rose(rsp.valid), $past(load_rsp), "stray")

endmodule

>>> hdl/nlpc_muldiv.sv
// Computes trunc(a * b / d) with one multiply followed by a restoring
// divider that retires one quotient bit per cycle.
module nlpc_muldiv import nlpc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  md_req_type md_req,
   output md_rsp_type md_rsp
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROD_W - 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      neg_ff, neg_in;
   logic [RANGE_W-1:0]        den_ff, den_in;
   logic [RANGE_W:0]          rem_ff, rem_in;
   logic [PROD_W-1:0]         quo_ff, quo_in;

   logic [ANGLE_W-1:0]        a_mag;
   logic [ANGLE_W+RANGE_W-1:0] product;
   logic [RANGE_W:0]          shifted;
   logic [RANGE_W+1:0]        trial;
   logic [PROD_W-1:0]         quo_signed;

   assign a_mag   = md_req.a[ANGLE_W-1] ? (~md_req.a + 1'b1) : md_req.a;
   assign product = a_mag * md_req.b;
   assign shifted = {rem_ff[RANGE_W-1:0], quo_ff[PROD_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (md_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         neg_in  = md_req.a[ANGLE_W-1];
         den_in  = md_req.d;
         rem_in  = '0;
         quo_in  = product[PROD_W-1:0];
      end else if (busy_ff) begin
         quo_in = {quo_ff[PROD_W-2:0], ~trial[RANGE_W+1]};
         rem_in = trial[RANGE_W+1] ? shifted : trial[RANGE_W:0];
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quo_signed  = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign md_rsp.busy = busy_ff;
   assign md_rsp.done = done_ff;
   assign md_rsp.quot = quo_signed[ANGLE_W-1:0];

endmodule

>>> hdl/nlpc_barrels.sv
// Per-barrel mode sequencer and saturating hold timer.
module nlpc_barrels import nlpc_pkg::*; #(
   parameter int NUM_BARRELS = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  barrel_cmd_type cmd,
   output mode_type       modes [MAX_BARRELS]
);

   for (genvar i = 0; i < MAX_BARRELS; i++) begin : g_barrel
      if (i < NUM_BARRELS) begin : g_live
         localparam logic [SEL_W-1:0] SEL_ID = SEL_W'(i + 1);

         mode_type           mode_ff, mode_in;
         logic [TIMER_W-1:0] timer_ff, timer_in;
         logic [TIMER_W:0]   timer_sum;
         logic [TIMER_W-1:0] timer_sat;
         logic               hit;

         assign timer_sum = {1'b0, timer_ff} + {1'b0, cmd.elapsed};
         assign timer_sat = timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];
         assign hit = (cmd.sel == SEL_ALL) || (cmd.sel == SEL_ID);

         always_comb begin
            mode_in  = mode_ff;
            timer_in = timer_ff;
            unique case (cmd.kind)
               BCMD_TICK: begin
                  timer_in = timer_sat;
                  if (mode_ff != MODE_NORMAL && timer_sat > cmd.hold) begin
                     mode_in = MODE_NORMAL;
                  end
               end
               BCMD_FIRE, BCMD_CUT: begin
                  if (hit && mode_ff == MODE_NORMAL) begin
                     mode_in  = (cmd.kind == BCMD_FIRE) ? MODE_FIRED : MODE_CUT;
                     timer_in = '0;
                  end
               end
               default: begin
               end
            endcase
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               mode_ff  <= MODE_NORMAL;
               timer_ff <= '0;
            end else begin
               mode_ff  <= mode_in;
               timer_ff <= timer_in;
            end
         end

         assign modes[i] = mode_ff;
      end else begin : g_absent
         assign modes[i] = MODE_NORMAL;
      end
   end

endmodule
